>>> hdl/cif_pkg.sv
// shared types and constants for the credible interval finder
// used by cif_ctrl, cif_dp and the top level
`default_nettype none

package cif_pkg;

   localparam int CIF_MAX_POINTS = 1024;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_DIFF,
      OP_SEGMUL,
      OP_AREA,
      OP_CUT0,
      OP_CUT1,
      OP_CUT2,
      OP_QH,
      OP_QL,
      OP_QE,
      OP_WINIT,
      OP_RD,
      OP_SHIFT,
      OP_SEGSET,
      OP_CHECK,
      OP_DIVT,
      OP_DIVU,
      OP_DIVSTEP,
      OP_TSET,
      OP_SQ,
      OP_SQSET,
      OP_SQRT0,
      OP_SQRTSTEP,
      OP_DEN,
      OP_NUM,
      OP_OFFMUL,
      OP_UPPER,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      Q_LOW,
      Q_HIGH,
      Q_DISC0,
      Q_DISC1
   } qsel_type;

   typedef struct packed {
      logic     take;
      op_type   op;
      qsel_type qsel;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic seg_needed;
      logic area_pos;
      logic walk_first;
      logic walk_end;
      logic hi_found;
      logic div_done;
      logic sqrt_done;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

>>> hdl/cif_regs.sv
// configuration registers behind the csr port
// depends on nothing but the port signals
`default_nettype none

module cif_regs (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output logic [16:0]      alpha,
   output logic [16:0]      share
);
   logic [16:0] alpha_ff, share_ff;
   logic        wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= 17'd3277;
         share_ff <= 17'd32768;
      end else if (wr) begin
         if (csr_paddr[2]) begin
            share_ff <= csr_pwdata[16:0];
         end else begin
            alpha_ff <= csr_pwdata[16:0];
         end
      end
   end

   assign csr_prdata = csr_paddr[2] ? {15'd0, share_ff} : {15'd0, alpha_ff};
   assign alpha = alpha_ff;
   assign share = share_ff;

endmodule

`default_nettype wire

>>> hdl/cif_ctrl.sv
// sequencer for load, normalize, walk and quadratic solve
// depends on cif_pkg; drives cif_dp through cmd_type
`default_nettype none

module cif_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire cif_pkg::sts_type sts,
   output cif_pkg::cmd_type      cmd
);
   import cif_pkg::*;

   typedef enum logic [31:0] {
      S_IDLE     = 32'h0000_0001,
      S_DIFF     = 32'h0000_0002,
      S_SEGMUL   = 32'h0000_0004,
      S_AREA     = 32'h0000_0008,
      S_FIN      = 32'h0000_0010,
      S_CUT0     = 32'h0000_0020,
      S_CUT1     = 32'h0000_0040,
      S_CUT2     = 32'h0000_0080,
      S_QH       = 32'h0000_0100,
      S_QL       = 32'h0000_0200,
      S_QE       = 32'h0000_0400,
      S_WINIT    = 32'h0000_0800,
      S_RD       = 32'h0000_1000,
      S_SHIFT    = 32'h0000_2000,
      S_WDIFF    = 32'h0000_4000,
      S_WMUL     = 32'h0000_8000,
      S_WSEG     = 32'h0001_0000,
      S_WCHK     = 32'h0002_0000,
      S_DIVT     = 32'h0004_0000,
      S_DIVT_RUN = 32'h0008_0000,
      S_TSET     = 32'h0010_0000,
      S_SQ       = 32'h0020_0000,
      S_SQSET    = 32'h0040_0000,
      S_SQRT0    = 32'h0080_0000,
      S_SQRT     = 32'h0100_0000,
      S_DEN      = 32'h0200_0000,
      S_NUM      = 32'h0400_0000,
      S_DIVU     = 32'h0800_0000,
      S_DIVU_RUN = 32'h1000_0000,
      S_OFFMUL   = 32'h2000_0000,
      S_UPPER    = 32'h4000_0000,
      S_EMIT     = 32'h8000_0000
   } state_type;

   state_type state_ff, state_in;
   qsel_type  qsel_ff, qsel_in;
   op_type    op;

   always_comb begin
      state_in = state_ff;
      qsel_in  = qsel_ff;
      op       = OP_NOP;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_DIFF;
         end
         S_DIFF: begin
            op = OP_DIFF;
            if (sts.seg_needed) state_in = S_SEGMUL;
            else if (sts.last) state_in = S_FIN;
            else state_in = S_IDLE;
         end
         S_SEGMUL: begin
            op = OP_SEGMUL;
            state_in = S_AREA;
         end
         S_AREA: begin
            op = OP_AREA;
            state_in = sts.last ? S_FIN : S_IDLE;
         end
         S_FIN: begin
            state_in = sts.area_pos ? S_CUT0 : S_EMIT;
         end
         S_CUT0: begin
            op = OP_CUT0;
            state_in = S_CUT1;
         end
         S_CUT1: begin
            op = OP_CUT1;
            state_in = S_CUT2;
         end
         S_CUT2: begin
            op = OP_CUT2;
            qsel_in = Q_LOW;
            state_in = S_QH;
         end
         S_QH: begin
            op = OP_QH;
            state_in = S_QL;
         end
         S_QL: begin
            op = OP_QL;
            state_in = S_QE;
         end
         S_QE: begin
            op = OP_QE;
            case (qsel_ff)
               Q_LOW: begin
                  qsel_in = Q_HIGH;
                  state_in = S_QH;
               end
               Q_HIGH: state_in = S_WINIT;
               Q_DISC0: begin
                  qsel_in = Q_DISC1;
                  state_in = S_SQ;
               end
               default: state_in = S_SQRT0;
            endcase
         end
         S_WINIT: begin
            op = OP_WINIT;
            state_in = S_RD;
         end
         S_RD: begin
            op = OP_RD;
            state_in = S_SHIFT;
         end
         S_SHIFT: begin
            op = OP_SHIFT;
            state_in = sts.walk_first ? S_RD : S_WDIFF;
         end
         S_WDIFF: begin
            op = OP_DIFF;
            state_in = S_WMUL;
         end
         S_WMUL: begin
            op = OP_SEGMUL;
            state_in = S_WSEG;
         end
         S_WSEG: begin
            op = OP_SEGSET;
            state_in = S_WCHK;
         end
         S_WCHK: begin
            op = OP_CHECK;
            state_in = S_RD;
         end
         S_DIVT: begin
            op = OP_DIVT;
            state_in = S_DIVT_RUN;
         end
         S_DIVT_RUN: begin
            if (sts.div_done) state_in = S_TSET;
            else op = OP_DIVSTEP;
         end
         S_TSET: begin
            op = OP_TSET;
            qsel_in = Q_DISC0;
            state_in = S_SQ;
         end
         S_SQ: begin
            op = OP_SQ;
            state_in = S_SQSET;
         end
         S_SQSET: begin
            op = OP_SQSET;
            state_in = S_QH;
         end
         S_SQRT0: begin
            op = OP_SQRT0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            if (sts.sqrt_done) state_in = S_DEN;
            else op = OP_SQRTSTEP;
         end
         S_DEN: begin
            op = OP_DEN;
            state_in = S_NUM;
         end
         S_NUM: begin
            op = OP_NUM;
            state_in = S_DIVU;
         end
         S_DIVU: begin
            op = OP_DIVU;
            state_in = S_DIVU_RUN;
         end
         S_DIVU_RUN: begin
            if (sts.div_done) state_in = S_OFFMUL;
            else op = OP_DIVSTEP;
         end
         S_OFFMUL: begin
            op = OP_OFFMUL;
            state_in = S_UPPER;
         end
         S_UPPER: begin
            op = OP_UPPER;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               op = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // walk end is decided after the check of the last segment
      if (state_ff == S_WCHK && sts.walk_end) state_in = sts.hi_found ? S_DIVT : S_EMIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         qsel_ff  <= Q_LOW;
      end else begin
         state_ff <= state_in;
         qsel_ff  <= qsel_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign cmd.take   = req_tready && req_tvalid;
   assign cmd.op     = op;
   assign cmd.qsel   = qsel_ff;

endmodule

`default_nettype wire

>>> hdl/cif_dp.sv
// datapath: point stores, shared multiplier, divider, square root, output register
// depends on cif_pkg; commanded by cif_ctrl
`default_nettype none

module cif_dp #(
   parameter int MAX_POINTS = cif_pkg::CIF_MAX_POINTS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cif_pkg::cmd_type cmd,
   output cif_pkg::sts_type      sts,
   input  wire logic [63:0]      req_tdata,
   input  wire logic             req_tlast,
   input  wire logic [16:0]      alpha,
   input  wire logic [16:0]      share,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [63:0]           rsp_tdata,
   output logic                  rsp_tuser
);
   import cif_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);
   localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

   logic [31:0] x_mem [MAX_POINTS];
   logic [31:0] y_mem [MAX_POINTS];

   logic [CW-1:0] count_ff, rd_idx_ff;
   logic          last_ff, seg_needed_ff;
   logic [31:0]   p0_x_ff, p0_y_ff, p1_x_ff, p1_y_ff, rd_x_ff, rd_y_ff;
   logic [32:0]   dxabs_ff, ys_ff;
   logic          dxneg_ff;
   logic [63:0]   area_ff, cum_ff, seg_ff, low_t_ff, high_t_ff, acc_ff, sq_ff, disc_ff;
   logic [65:0]   prod_ff;
   logic [32:0]   low_cut_ff, high_cut_ff, t_ff, den_ff;
   logic [33:0]   num_ff;
   logic [31:0]   lower_ff, upper_ff;
   logic          found_ff;
   logic [31:0]   sx0_ff, sy0_ff, sy1_ff;
   logic [32:0]   sad_ff;
   logic          sneg_ff;
   logic [63:0]   sseg_ff, srest_ff;
   logic [64:0]   rem_ff;
   logic [63:0]   dden_ff;
   logic [32:0]   q_ff;
   logic [5:0]    div_cnt_ff, sqrt_cnt_ff;
   logic [63:0]   sv_ff, sres_ff, sbit_ff;
   logic          rsp_valid_ff, rsp_status_ff;
   logic [63:0]   rsp_data_ff;

   logic [16:0]   a_c, s_c;
   logic [32:0]   mul_a, mul_b;
   logic          mul_en;
   logic [63:0]   qa, qres, cum_seg, seg_val;
   logic [32:0]   qt, dx_s, ysum_s;
   logic          store_ok;
   logic          hi_cross;
   logic [64:0]   rem2;
   logic [63:0]   root_try;

   assign a_c = (alpha > 17'd65536) ? 17'd65536 : alpha;
   assign s_c = (share > 17'd65536) ? 17'd65536 : share;
   assign store_ok = (count_ff < MAX_CNT);

   assign qa = (cmd.qsel == Q_LOW || cmd.qsel == Q_HIGH) ? area_ff : sq_ff;
   always_comb begin
      case (cmd.qsel)
         Q_LOW:   qt = low_cut_ff;
         Q_HIGH:  qt = high_cut_ff;
         Q_DISC0: qt = ONE_Q32 - t_ff;
         default: qt = t_ff;
      endcase
   end
   assign qres = acc_ff + {30'd0, prod_ff[65:32]};

   // shared multiplier operand select
   always_comb begin
      mul_en = 1'b1;
      mul_a  = 33'd0;
      mul_b  = 33'd0;
      case (cmd.op)
         OP_SEGMUL: begin
            mul_a = dxabs_ff;
            mul_b = ys_ff;
         end
         OP_CUT0: begin
            mul_a = {16'd0, a_c};
            mul_b = {16'd0, s_c};
         end
         OP_CUT1: begin
            mul_a = 33'd65536 - {16'd0, s_c};
            mul_b = {16'd0, a_c};
         end
         OP_QH: begin
            mul_a = {1'b0, qa[63:32]};
            mul_b = qt;
         end
         OP_QL: begin
            mul_a = {1'b0, qa[31:0]};
            mul_b = qt;
         end
         OP_SQ: begin
            mul_a = (cmd.qsel == Q_DISC0) ? {1'b0, sy0_ff} : {1'b0, sy1_ff};
            mul_b = mul_a;
         end
         OP_DEN: begin
            mul_a = {1'b0, sy0_ff} + {1'b0, sy1_ff};
            mul_b = t_ff;
         end
         OP_OFFMUL: begin
            mul_a = sad_ff;
            mul_b = q_ff;
         end
         default: mul_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mul_en) prod_ff <= mul_a * mul_b;
   end

   // point stores
   always_ff @(posedge clock) begin
      if (cmd.take && store_ok) begin
         x_mem[count_ff[AW-1:0]] <= req_tdata[31:0];
         y_mem[count_ff[AW-1:0]] <= req_tdata[63:32];
      end
      if (cmd.op == OP_RD) begin
         rd_x_ff <= x_mem[rd_idx_ff[AW-1:0]];
         rd_y_ff <= y_mem[rd_idx_ff[AW-1:0]];
      end
   end

   assign dx_s    = {p1_x_ff[31], p1_x_ff} - {p0_x_ff[31], p0_x_ff};
   assign ysum_s  = {1'b0, p0_y_ff} + {1'b0, p1_y_ff};
   assign seg_val = dxneg_ff ? (64'd0 - {15'd0, prod_ff[65:17]}) : {15'd0, prod_ff[65:17]};
   assign cum_seg = cum_ff + seg_ff;
   assign hi_cross = $signed(cum_ff) <= $signed(high_t_ff)
                     && $signed(cum_seg) >= $signed(high_t_ff);

   // load, normalization and walk
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         last_ff <= req_tlast;
         seg_needed_ff <= store_ok && (count_ff != '0);
         if (store_ok) begin
            p0_x_ff <= p1_x_ff;
            p0_y_ff <= p1_y_ff;
            p1_x_ff <= req_tdata[31:0];
            p1_y_ff <= req_tdata[63:32];
         end
      end
      case (cmd.op)
         OP_DIFF: begin
            dxneg_ff <= dx_s[32];
            dxabs_ff <= dx_s[32] ? (33'd0 - dx_s) : dx_s;
            ys_ff    <= ysum_s;
         end
         OP_CUT1: low_cut_ff <= prod_ff[32:0];
         OP_CUT2: high_cut_ff <= ONE_Q32 - prod_ff[32:0];
         OP_QL: acc_ff <= prod_ff[63:0];
         OP_QE: begin
            case (cmd.qsel)
               Q_LOW:   low_t_ff <= qres;
               Q_HIGH:  high_t_ff <= qres;
               Q_DISC0: disc_ff <= qres;
               default: disc_ff <= disc_ff + qres;
            endcase
         end
         OP_SHIFT: begin
            p0_x_ff <= p1_x_ff;
            p0_y_ff <= p1_y_ff;
            p1_x_ff <= rd_x_ff;
            p1_y_ff <= rd_y_ff;
         end
         OP_SEGSET: seg_ff <= seg_val;
         OP_CHECK: begin
            if ($signed(cum_ff) <= $signed(low_t_ff) && $signed(cum_seg) >= $signed(low_t_ff))
               lower_ff <= p0_x_ff;
            if (hi_cross) begin
               sx0_ff   <= p0_x_ff;
               sy0_ff   <= p0_y_ff;
               sy1_ff   <= p1_y_ff;
               sad_ff   <= dxabs_ff;
               sneg_ff  <= dxneg_ff;
               sseg_ff  <= seg_ff;
               srest_ff <= high_t_ff - cum_ff;
            end
            cum_ff <= cum_seg;
         end
         OP_WINIT: begin
            cum_ff   <= 64'd0;
            lower_ff <= 32'd0;
            upper_ff <= 32'd0;
         end
         OP_TSET: t_ff <= q_ff;
         OP_SQSET: sq_ff <= prod_ff[63:0];
         OP_DEN: den_ff <= {1'b0, sy0_ff} + {1'b0, sres_ff[31:0]};
         OP_NUM: num_ff <= prod_ff[65:32];
         OP_UPPER: begin
            upper_ff <= sneg_ff ? (sx0_ff - prod_ff[63:32]) : (sx0_ff + prod_ff[63:32]);
         end
         default: ;
      endcase
   end

   // control state of the load and walk
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         area_ff   <= 64'd0;
         rd_idx_ff <= '0;
         found_ff  <= 1'b0;
      end else begin
         if (cmd.take && store_ok) count_ff <= count_ff + 1'b1;
         case (cmd.op)
            OP_AREA: area_ff <= area_ff + seg_val;
            OP_WINIT: begin
               rd_idx_ff <= '0;
               found_ff  <= 1'b0;
            end
            OP_RD: rd_idx_ff <= rd_idx_ff + 1'b1;
            OP_CHECK: begin
               if (hi_cross) found_ff <= 1'b1;
            end
            OP_EMIT: begin
               count_ff <= '0;
               area_ff  <= 64'd0;
            end
            default: ;
         endcase
      end
   end

   // restoring divider, one quotient bit per cycle
   assign rem2 = {rem_ff[63:0], 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= 6'd0;
      end else begin
         case (cmd.op)
            OP_DIVT: begin
               rem_ff  <= {1'b0, srest_ff};
               dden_ff <= sseg_ff;
               if ($signed(sseg_ff) <= 64'sd0) begin
                  q_ff <= 33'd0;
                  div_cnt_ff <= 6'd0;
               end else if (srest_ff >= sseg_ff) begin
                  q_ff <= ONE_Q32;
                  div_cnt_ff <= 6'd0;
               end else begin
                  q_ff <= 33'd0;
                  div_cnt_ff <= 6'd32;
               end
            end
            OP_DIVU: begin
               rem_ff  <= {31'd0, num_ff};
               dden_ff <= {31'd0, den_ff};
               if (den_ff == 33'd0) begin
                  q_ff <= 33'd0;
                  div_cnt_ff <= 6'd0;
               end else if ({1'b0, num_ff} >= {2'b0, den_ff}) begin
                  q_ff <= ONE_Q32;
                  div_cnt_ff <= 6'd0;
               end else begin
                  q_ff <= 33'd0;
                  div_cnt_ff <= 6'd32;
               end
            end
            OP_DIVSTEP: begin
               if (rem2 >= {1'b0, dden_ff}) begin
                  rem_ff <= rem2 - {1'b0, dden_ff};
                  q_ff   <= {q_ff[31:0], 1'b1};
               end else begin
                  rem_ff <= rem2;
                  q_ff   <= {q_ff[31:0], 1'b0};
               end
               div_cnt_ff <= div_cnt_ff - 6'd1;
            end
            default: ;
         endcase
      end
   end

   // square root, one result bit per cycle
   assign root_try = sres_ff + sbit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sqrt_cnt_ff <= 6'd0;
      end else begin
         case (cmd.op)
            OP_SQRT0: begin
               sv_ff       <= disc_ff;
               sres_ff     <= 64'd0;
               sbit_ff     <= 64'h4000_0000_0000_0000;
               sqrt_cnt_ff <= 6'd32;
            end
            OP_SQRTSTEP: begin
               if (sv_ff >= root_try) begin
                  sv_ff   <= sv_ff - root_try;
                  sres_ff <= (sres_ff >> 1) + sbit_ff;
               end else begin
                  sres_ff <= sres_ff >> 1;
               end
               sbit_ff     <= sbit_ff >> 2;
               sqrt_cnt_ff <= sqrt_cnt_ff - 6'd1;
            end
            default: ;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_EMIT) begin
         rsp_status_ff <= !sts.area_pos;
         rsp_data_ff   <= sts.area_pos ? {upper_ff, lower_ff} : 64'd0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   assign sts.last       = last_ff;
   assign sts.seg_needed = seg_needed_ff;
   assign sts.area_pos   = $signed(area_ff) > 64'sd0;
   assign sts.walk_first = (rd_idx_ff == CW'(1));
   assign sts.walk_end   = (rd_idx_ff == count_ff);
   // includes the segment under check so the last segment counts
   assign sts.hi_found   = found_ff || hi_cross;
   assign sts.div_done   = (div_cnt_ff == 6'd0);
   assign sts.sqrt_done  = (sqrt_cnt_ff == 6'd0);
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("point count beyond store depth");

   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_RD |-> rd_idx_ff < count_ff)
      else $error("walk reads past loaded points");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_EMIT |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before transfer");

   a_div_step: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_DIVSTEP |-> div_cnt_ff != 6'd0)
      else $error("divider stepped after finishing");

endmodule

`default_nettype wire

>>> hdl/credible_interval_finder.sv
// credible interval finder top level: csr registers, sequencer and datapath
// depends on cif_pkg, cif_regs, cif_ctrl, cif_dp
//
// channel  direction  tdata                              tuser / tlast
// req      in         [31:0] point_x, [63:32] point_y    tlast is_last
// rsp      out        [31:0] lower_bound, [63:32] upper  tuser status
// csr      in/out     alpha at 0x0, left_tail_share 0x4  -
//
// per point: accept, difference, multiply, accumulate; the last two only if a segment is added
// the finish walks the stores per segment: read, shift, difference, shared multiply, set, check
// the quadratic solve adds two divides of up to 32 steps and a 32-step root
// reset is synchronous; point stores are not cleared, only the fill count
// req is not ready during the finish; a result waiting on rsp does not stop loading
`default_nettype none

module credible_interval_finder #(
   parameter int MAX_POINTS = cif_pkg::CIF_MAX_POINTS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // [31:0] point_x, [63:32] point_y
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // [31:0] lower_bound, [63:32] upper_bound
   output logic             rsp_tuser,   // [0] status
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import cif_pkg::*;

   cmd_type     cmd;
   sts_type     sts;
   logic [16:0] alpha, share;

   cif_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .alpha       (alpha),
      .share       (share)
   );

   cif_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   cif_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .alpha      (alpha),
      .share      (share),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

>>> sim/cif_checker.sv
// transfer monitor, result predictor and scoreboard for the credible interval finder
// watches the req, rsp and csr ports of the block; depends on nothing else
module cif_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [63:0] req_tdata,
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [63:0] rsp_tdata,
   input  wire logic        rsp_tuser,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               fail_count,
   output int               pending
);

   localparam int          DEPTH      = 1024;
   localparam logic [2:0]  ALPHA_ADDR = 3'd0;
   localparam logic [2:0]  SHARE_ADDR = 3'd4;
   localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;

   typedef struct {
      logic [31:0] lower;
      logic [31:0] upper;
      logic        status;
   } interval_type;

   logic [31:0]  x_mem [DEPTH];
   logic [31:0]  y_mem [DEPTH];
   int           fill;
   longint       area_sum;
   logic [16:0]  alpha_reg;
   logic [16:0]  share_reg;
   interval_type interval_q[$];

   assign pending = interval_q.size();

   // floor(a * t / 2^32), wrapped to 64 bits
   function automatic logic [63:0] scale_q32(logic [63:0] a, logic [63:0] t);
      logic [127:0] p;
      p = {64'b0, a} * {64'b0, t};
      return p[95:32];
   endfunction

   // floor(2^32 * num / den) saturated to 2^32
   function automatic logic [63:0] ratio_q32(logic [63:0] num, logic [63:0] den);
      logic [127:0] p;
      if (num >= den) return {31'b0, ONE_Q32};
      p = {32'b0, num, 32'b0} / {64'b0, den};
      return p[63:0];
   endfunction

   function automatic logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] root, bitv;
      root = 0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic longint trap_area(int i);
      longint       dx;
      logic [63:0]  ad, ys;
      logic [127:0] p;
      dx = longint'($signed(x_mem[i+1])) - longint'($signed(x_mem[i]));
      ad = dx < 0 ? -dx : dx;
      ys = {32'b0, y_mem[i]} + {32'b0, y_mem[i+1]};
      p  = ({64'b0, ad} * {64'b0, ys}) >> 17;
      return dx < 0 ? -longint'(p[63:0]) : longint'(p[63:0]);
   endfunction

   function automatic longint upper_edge(int i, longint seg, longint rest);
      longint      x0, dx;
      logic [63:0] y0, y1, t, disc, den, num, u, ad, off;
      x0   = longint'($signed(x_mem[i]));
      dx   = longint'($signed(x_mem[i+1])) - x0;
      y0   = {32'b0, y_mem[i]};
      y1   = {32'b0, y_mem[i+1]};
      t    = seg > 0 ? ratio_q32(rest, seg) : 64'd0;
      disc = scale_q32(y0 * y0, {31'b0, ONE_Q32} - t) + scale_q32(y1 * y1, t);
      den  = y0 + floor_sqrt(disc);
      num  = scale_q32(y0 + y1, t);
      u    = den != 0 ? ratio_q32(num, den) : 64'd0;
      ad   = dx < 0 ? -dx : dx;
      off  = scale_q32(ad, u);
      return dx < 0 ? x0 - longint'(off) : x0 + longint'(off);
   endfunction

   function automatic interval_type find_interval();
      interval_type r;
      logic [63:0]  a, s, low_cut, high_cut;
      longint       low_t, high_t, cum, seg;
      r.lower  = 0;
      r.upper  = 0;
      r.status = 0;
      a = alpha_reg > 17'd65536 ? 64'd65536 : {47'b0, alpha_reg};
      s = share_reg > 17'd65536 ? 64'd65536 : {47'b0, share_reg};
      low_cut  = a * s;
      high_cut = {31'b0, ONE_Q32} - (64'd65536 - s) * a;
      if (area_sum <= 0) begin
         r.status = 1;
      end else begin
         low_t  = longint'(scale_q32(area_sum, low_cut));
         high_t = longint'(scale_q32(area_sum, high_cut));
         cum = 0;
         for (int i = 0; i + 1 < fill; i++) begin
            seg = trap_area(i);
            if (cum <= low_t && cum + seg >= low_t) r.lower = x_mem[i];
            if (cum <= high_t && cum + seg >= high_t)
               r.upper = 32'(upper_edge(i, seg, high_t - cum));
            cum += seg;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      interval_type got, want;
      int           errs;
      errs = 0;
      if (reset) begin
         fill       = 0;
         area_sum   = 0;
         alpha_reg  <= 17'd3277;
         share_reg  <= 17'd32768;
         fail_count <= 0;
         interval_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == ALPHA_ADDR) alpha_reg <= csr_pwdata[16:0];
            if (csr_paddr == SHARE_ADDR) share_reg <= csr_pwdata[16:0];
         end
         if (req_tvalid && req_tready) begin
            if (fill < DEPTH) begin
               x_mem[fill] = req_tdata[31:0];
               y_mem[fill] = req_tdata[63:32];
               if (fill > 0) area_sum = area_sum + trap_area(fill - 1);
               fill = fill + 1;
            end
            if (req_tlast) begin
               interval_q.push_back(find_interval());
               fill = 0;
               area_sum = 0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.lower  = rsp_tdata[31:0];
            got.upper  = rsp_tdata[63:32];
            got.status = rsp_tuser;
            if (interval_q.size() == 0) begin
               $error("unexpected result transfer");
               errs = errs + 1;
            end else begin
               want = interval_q.pop_front();
               if (got.lower !== want.lower) begin
                  $error("lower_bound expected %h got %h", want.lower, got.lower);
                  errs = errs + 1;
               end
               if (got.upper !== want.upper) begin
                  $error("upper_bound expected %h got %h", want.upper, got.upper);
                  errs = errs + 1;
               end
               if (got.status !== want.status) begin
                  $error("status expected %b got %b", want.status, got.status);
                  errs = errs + 1;
               end
            end
         end
         if (errs != 0) fail_count <= fail_count + errs;
      end
   end

endmodule

>>> sim/tb_credible_interval_finder.sv
// testbench top for credible_interval_finder: clock, reset, point and register stimulus
// depends on the block's rtl and on cif_checker, which predicts and compares results
module tb_credible_interval_finder;

   localparam logic [2:0] ALPHA_ADDR = 3'd0;
   localparam logic [2:0] SHARE_ADDR = 3'd4;
   localparam int         CYCLE_LIMIT = 2000000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = 0;   // [31:0] point_x, [63:32] point_y
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1;
   logic [63:0] rsp_tdata;       // [31:0] lower_bound, [63:32] upper_bound
   logic        rsp_tuser;       // [0] status
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [2:0]  csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending;
   int          cycles = 0;
   int          stall_hold = 0;
   bit          quiet = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   credible_interval_finder u_top (.*);

   cif_checker u_checker (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // result side back-pressure in bursts
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_tready <= 1;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_tready <= ~rsp_tready;
         stall_hold <= $urandom_range(0, 7);
      end
   end

   task automatic send_point(logic [31:0] x, logic [31:0] y, logic last);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {y, x};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      csr_psel    <= 1;
      csr_pwrite  <= 1;
      csr_penable <= 0;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
   endtask

   task automatic set_tails(logic [31:0] a, logic [31:0] s);
      drain();
      csr_write(ALPHA_ADDR, a);
      csr_write(SHARE_ADDR, s);
   endtask

   function automatic logic [31:0] rand_y();
      return $urandom() >> $urandom_range(0, 31);
   endfunction

   // shape: 0 ascending, 1 flat density, 2 descending, 3 unordered full range
   task automatic send_density(int n, int shape);
      logic [31:0] x, y;
      x = $urandom();
      y = rand_y();
      for (int i = 0; i < n; i++) begin
         if (shape == 3) begin
            x = $urandom();
            y = $urandom();
         end else if (shape != 1) begin
            y = rand_y();
         end
         send_point(x, y, i == n - 1);
         if (shape == 2) x = x - $urandom_range(1, 1 << $urandom_range(0, 20));
         else x = x + $urandom_range(1, 1 << $urandom_range(0, 20));
      end
   endtask

   initial begin
      int sent;
      int n;
      repeat (3) @(posedge clock);
      reset <= 0;

      // single point, zero density, flat, descending, extremes, repeated x
      send_point(32'h0001_0000, 32'h0001_0000, 1);
      send_point(32'h0000_0000, 32'h0, 0);
      send_point(32'h0002_0000, 32'h0, 1);
      send_density(5, 1);
      send_density(4, 2);
      send_point(32'h8000_0000, 32'hFFFF_FFFF, 0);
      send_point(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1);
      send_point(32'h0000_0000, 32'h0001_0000, 0);
      send_point(32'h0000_0000, 32'h0002_0000, 0);
      send_point(32'h0001_0000, 32'h0000_0000, 1);

      set_tails(0, 0);
      send_density(6, 0);
      set_tails(65536, 65536);
      send_density(6, 0);
      set_tails(32'h1FFFF, 32'h1FFFF);
      send_density(6, 3);
      set_tails(65536, 0);
      send_density(6, 0);
      set_tails(3277, 32768);

      // more points than the stores hold
      for (int i = 0; i < 1030; i++)
         send_point(32'h0000_1000 * i, rand_y(), i == 1029);

      sent = 0;
      while (sent < 500) begin
         if ($urandom_range(0, 14) == 0)
            set_tails($urandom_range(0, 70000), $urandom_range(0, 70000));
         if (sent > 400) quiet = 1;
         n = $urandom_range(1, 12);
         send_density(n, $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 3));
         sent += n;
      end

      drain();
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
